### sv/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, reduction constants, controller/datapath structs and the
// single restoring-reduction step shared by the reduction units.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int BASE_W    = 63;
	localparam int EXP_W     = 63;
	localparam int MOD_W     = 32;
	localparam int PROD_W    = 2 * MOD_W;
	localparam int RED_STEPS = 2;
	localparam int RED_ITER  = PROD_W / RED_STEPS;
	localparam int CNT_W     = $clog2(RED_ITER);

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture operands, start base reduction
		logic take_base;   // square register takes the reduced base
		logic start_step;  // start both modular products
		logic take_step;   // retire one exponent bit
		logic publish;     // load the result register
	} modexp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic exp_zero;
		logic red_done;
	} modexp_sts_t;

	// one restoring step: shift in a dividend bit, subtract m if it fits
	function automatic logic [MOD_W-1:0] red_step(
		input logic [MOD_W-1:0] r,
		input logic             b,
		input logic [MOD_W-1:0] m
	);
		logic [MOD_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[MOD_W-1:0];
	endfunction

endpackage

### sv/modexp_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Operand and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface modexp_in_if;
	logic                           valid;
	logic                           ready;
	logic [modexp_pkg::BASE_W-1:0]  base_value;
	logic [modexp_pkg::EXP_W-1:0]   exponent_value;
	logic [modexp_pkg::MOD_W-1:0]   modulus_value;

	modport source (output valid, base_value, exponent_value, modulus_value, input ready);
	modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

interface modexp_out_if;
	logic                           valid;
	logic                           ready;
	logic [modexp_pkg::MOD_W-1:0]   power_residue;

	modport source (output valid, power_residue, input ready);
	modport sink   (input valid, power_residue, output ready);
endinterface

### sv/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation, square and multiply
// One round per exponent bit, so at most 63 rounds (EXP_W) for the longest exponent.
// A new operand word is taken only in idle, after the last result is published.
// Output register lets the next operand word in while a result waits.
// Reset (arst_n low, asynchronous) empties the controller and drops results.
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
	input  logic                clk,
	input  logic                arst_n,
	modexp_in_if.sink           operands,
	modexp_out_if.source        results
);

	// command and status between sequencer and datapath
	modexp_pkg::modexp_cmd_t cmd;
	modexp_pkg::modexp_sts_t sts;

	// controller: accepts an operand word in idle, walks the exponent bits
	// one round at a time, and hands the result to the output register
	modexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: reduce the base, then per exponent bit form acc*sq and
	// sq*sq in parallel units; hold the residue until the word is taken
	modexp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.base_value     (operands.base_value),
		.exponent_value (operands.exponent_value),
		.modulus_value  (operands.modulus_value),
		.power_residue  (results.power_residue)
	);

endmodule

### sv/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular product unit
// Registers a 32x32 product (or a direct dividend), then reduces it modulo m
// by restoring division, two dividend bits per cycle.
// ----------------------------------------------------------------------------
module modexp_mulmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          use_direct,
	input  logic [modexp_pkg::MOD_W-1:0]  a,
	input  logic [modexp_pkg::MOD_W-1:0]  b,
	input  logic [modexp_pkg::BASE_W-1:0] direct,
	input  logic [modexp_pkg::MOD_W-1:0]  m,
	output logic                          done,
	output logic [modexp_pkg::MOD_W-1:0]  rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [modexp_pkg::CNT_W-1:0]   cnt_q;
	logic [modexp_pkg::PROD_W-1:0]  div_q;
	logic [modexp_pkg::MOD_W-1:0]   rem_q;
	logic [modexp_pkg::PROD_W-1:0]  prod;
	logic [modexp_pkg::MOD_W-1:0]   rem_nxt;

	assign prod = a * b;

	always_comb begin
		logic [modexp_pkg::MOD_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < modexp_pkg::RED_STEPS; i++) begin
			r = modexp_pkg::red_step(r, div_q[modexp_pkg::PROD_W-1-i], m);
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + modexp_pkg::CNT_W'(1);
				if (cnt_q == modexp_pkg::CNT_W'(modexp_pkg::RED_ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= use_direct ? modexp_pkg::PROD_W'(direct) : prod;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= div_q << modexp_pkg::RED_STEPS;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("reduction restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished reduction");

endmodule

### sv/modexp_dp.sv
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Exponent shifter, accumulator and square registers, two modular product
// units working side by side, and the result register.
// ----------------------------------------------------------------------------
module modexp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  modexp_pkg::modexp_cmd_t       cmd,
	output modexp_pkg::modexp_sts_t       sts,
	input  logic [modexp_pkg::BASE_W-1:0] base_value,
	input  logic [modexp_pkg::EXP_W-1:0]  exponent_value,
	input  logic [modexp_pkg::MOD_W-1:0]  modulus_value,
	output logic [modexp_pkg::MOD_W-1:0]  power_residue
);

	logic [modexp_pkg::EXP_W-1:0] exp_q;
	logic [modexp_pkg::MOD_W-1:0] m_q;
	logic [modexp_pkg::MOD_W-1:0] acc_q;
	logic [modexp_pkg::MOD_W-1:0] sq_q;
	logic [modexp_pkg::MOD_W-1:0] res_q;
	logic                         done_a;
	logic                         done_b;
	logic [modexp_pkg::MOD_W-1:0] rem_a;
	logic [modexp_pkg::MOD_W-1:0] rem_b;

	// unit A: base reduction, then acc * sq
	modexp_mulmod u_mul_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.load | cmd.start_step),
		.use_direct (cmd.load),
		.a          (acc_q),
		.b          (sq_q),
		.direct     (base_value),
		.m          (m_q),
		.done       (done_a),
		.rem        (rem_a)
	);

	// unit B: sq * sq
	modexp_mulmod u_mul_sq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.start_step),
		.use_direct (1'b0),
		.a          (sq_q),
		.b          (sq_q),
		.direct     ('0),
		.m          (m_q),
		.done       (done_b),
		.rem        (rem_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			exp_q <= exponent_value;
			m_q   <= modulus_value;
			acc_q <= (modulus_value == modexp_pkg::MOD_W'(1)) ? '0 : modexp_pkg::MOD_W'(1);
		end
		if (cmd.take_base) begin
			sq_q <= rem_a;
		end
		if (cmd.take_step) begin
			if (exp_q[0]) begin
				acc_q <= rem_a;
			end
			sq_q  <= rem_b;
			exp_q <= exp_q >> 1;
		end
		if (cmd.publish) begin
			res_q <= (m_q == '0) ? '0 : acc_q;
		end
	end

	assign sts.exp_zero   = (exp_q == '0);
	assign sts.red_done   = done_a;
	assign power_residue  = res_q;

	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_step |-> done_b)
		else $error("product units out of step");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish && (m_q != '0) |=> res_q < m_q)
		else $error("result not reduced below modulus");

endmodule

### sv/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction and one square-and-multiply round per exponent
// bit, and owns the input ready and output valid.
// ----------------------------------------------------------------------------
module modexp_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output modexp_pkg::modexp_cmd_t cmd,
	input  modexp_pkg::modexp_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BASE,
		S_CHECK,
		S_STEP,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd            = '0;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_BASE:   cmd.take_base  = sts.red_done;
			S_CHECK:  cmd.start_step = !sts.exp_zero;
			S_STEP:   cmd.take_step  = sts.red_done;
			S_FINISH: cmd.publish    = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:   if (cmd.load)       state_q <= S_BASE;
				S_BASE:   if (cmd.take_base)  state_q <= S_CHECK;
				S_CHECK:  state_q <= sts.exp_zero ? S_FINISH : S_STEP;
				S_STEP:   if (cmd.take_step)  state_q <= S_CHECK;
				S_FINISH: if (cmd.publish)    state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_valid_from_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.publish))
		else $error("result word raised without publish");

	a_no_step_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_step |-> !sts.exp_zero)
		else $error("step retired on an empty exponent");

endmodule
